### hw/rtl/pgd_pkg.sv
// Shared types, widths and the microcode program of the processor grid search.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pgd_pkg;

   localparam int CNT_W  = 13;              // processor counts, splits, grid sizes
   localparam int PROD_W = 2 * CNT_W;       // product of two grid sizes
   localparam int ACC_W  = PROD_W + CNT_W;  // area terms and their sum
   localparam int AREA_W = 37;              // reported area
   localparam int STEP_W = 5;
   localparam int DIV_CNT_W = 4;

   localparam logic [CNT_W-1:0] PROCS_MAX = CNT_W'(4096);
   localparam logic [CNT_W-1:0] GRID_MAX  = CNT_W'(4096);

   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [ACC_W-1:0]  acc_type;
   typedef logic [AREA_W-1:0] area_type;
   typedef logic [STEP_W-1:0] step_type;

   // Configuration register indexes.
   localparam logic [2:0] REG_GRID_X = 3'd0;
   localparam logic [2:0] REG_GRID_Y = 3'd1;
   localparam logic [2:0] REG_GRID_Z = 3'd2;
   localparam logic [2:0] REG_WRAP_X = 3'd3;
   localparam logic [2:0] REG_WRAP_Y = 3'd4;
   localparam logic [2:0] REG_WRAP_Z = 3'd5;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_XY,
      OP_MUL_XZ,
      OP_MUL_YZ,
      OP_BOUND,
      OP_DIV_K,
      OP_SET_REST,
      OP_DIV_J,
      OP_SET_I,
      OP_MUL_ZK,
      OP_MUL_YJ,
      OP_MUL_XI,
      OP_SUM,
      OP_KEEP,
      OP_INC_J,
      OP_INC_K,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_REQ,
      C_DIV_BUSY,
      C_REM_NZ,
      C_K_GT_CNT,
      C_J_GT_REST,
      C_OUT_FULL
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic div_busy;
      logic rem_nz;
      logic k_gt_cnt;
      logic j_gt_rest;
      logic out_full;
   } status_type;

   typedef struct packed {
      cnt_type gx;
      cnt_type gy;
      cnt_type gz;
      logic    wx;
      logic    wy;
      logic    wz;
   } cfg_type;

   // Step addresses that are jump targets.
   localparam step_type S_IDLE  = 5'd0;
   localparam step_type S_KLOOP = 5'd5;
   localparam step_type S_KWAIT = 5'd7;
   localparam step_type S_JLOOP = 5'd9;
   localparam step_type S_JWAIT = 5'd11;
   localparam step_type S_NEXTJ = 5'd18;
   localparam step_type S_NEXTK = 5'd19;
   localparam step_type S_DONE  = 5'd20;

   // The search program: outer loop over k, inner loop over j, one division each pass.
   function automatic ucode_type pgd_ucode(step_type step);
      ucode_type w;
      case (step)
         5'd0:  w = '{OP_LOAD,     C_NO_REQ,    S_IDLE};
         5'd1:  w = '{OP_MUL_XY,   C_NEXT,      S_IDLE};
         5'd2:  w = '{OP_MUL_XZ,   C_NEXT,      S_IDLE};
         5'd3:  w = '{OP_MUL_YZ,   C_NEXT,      S_IDLE};
         5'd4:  w = '{OP_BOUND,    C_NEXT,      S_IDLE};
         5'd5:  w = '{OP_NONE,     C_K_GT_CNT,  S_DONE};
         5'd6:  w = '{OP_DIV_K,    C_NEXT,      S_IDLE};
         5'd7:  w = '{OP_NONE,     C_DIV_BUSY,  S_KWAIT};
         5'd8:  w = '{OP_SET_REST, C_REM_NZ,    S_NEXTK};
         5'd9:  w = '{OP_NONE,     C_J_GT_REST, S_NEXTK};
         5'd10: w = '{OP_DIV_J,    C_NEXT,      S_IDLE};
         5'd11: w = '{OP_NONE,     C_DIV_BUSY,  S_JWAIT};
         5'd12: w = '{OP_SET_I,    C_REM_NZ,    S_NEXTJ};
         5'd13: w = '{OP_MUL_ZK,   C_NEXT,      S_IDLE};
         5'd14: w = '{OP_MUL_YJ,   C_NEXT,      S_IDLE};
         5'd15: w = '{OP_MUL_XI,   C_NEXT,      S_IDLE};
         5'd16: w = '{OP_SUM,      C_NEXT,      S_IDLE};
         5'd17: w = '{OP_KEEP,     C_NEXT,      S_IDLE};
         5'd18: w = '{OP_INC_J,    C_ALWAYS,    S_JLOOP};
         5'd19: w = '{OP_INC_K,    C_ALWAYS,    S_KLOOP};
         5'd20: w = '{OP_OUT,      C_OUT_FULL,  S_DONE};
         default: w = '{OP_NONE,   C_ALWAYS,    S_IDLE};
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/pgd_divider.sv
// Restoring divider for the search, one quotient bit per cycle.
// Depends on pgd_pkg for the operand widths.
`timescale 1ns / 1ps

module pgd_divider (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  pgd_pkg::cnt_type dividend,
   input  pgd_pkg::cnt_type divisor,
   output logic           busy,
   output pgd_pkg::cnt_type quotient,
   output pgd_pkg::cnt_type remainder
);
   import pgd_pkg::*;

   cnt_type rem_ff, rem_in;
   cnt_type quo_ff, quo_in;
   cnt_type dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] bit_ff, bit_in;
   logic busy_ff, busy_in;

   logic [CNT_W:0] trial;
   logic [CNT_W:0] diff;
   logic           ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[CNT_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         bit_in  = DIV_CNT_W'(CNT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in = {quo_ff[CNT_W-2:0], ge};
         if (bit_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         bit_ff  <= bit_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### hw/rtl/pgd_datapath.sv
// Datapath of the search: loop counters, shared multiplier, area accumulator,
// best-so-far registers and the result register. Uses pgd_pkg and pgd_divider.
`timescale 1ns / 1ps

module pgd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pgd_pkg::op_type     op,
   input  pgd_pkg::cfg_type    cfg,
   input  logic                req_tvalid,
   input  pgd_pkg::cnt_type    req_count,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output pgd_pkg::cnt_type    rsp_split_x,
   output pgd_pkg::cnt_type    rsp_split_y,
   output pgd_pkg::cnt_type    rsp_split_z,
   output pgd_pkg::area_type   rsp_best_area,
   output logic                rsp_found,
   output pgd_pkg::status_type status
);
   import pgd_pkg::*;

   cnt_type  cnt_ff, cnt_in, k_ff, k_in, j_ff, j_in, rest_ff, rest_in, i_ff, i_in;
   prod_type xy_ff, xy_in, xz_ff, xz_in, yz_ff, yz_in;
   acc_type  mul_ff, mul_in, acc_ff, acc_in;
   area_type best_ff, best_in;
   cnt_type  bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic     hit_ff, hit_in;
   cnt_type  ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   area_type oa_ff, oa_in;
   logic     of_ff, of_in;
   logic     valid_ff, valid_in;

   prod_type mul_a;
   cnt_type  mul_b;
   acc_type  mul_p;
   cnt_type  fk, fj, fi;
   logic     out_full;

   logic     div_start, div_busy;
   cnt_type  div_num, div_den, div_quo, div_rem;

   pgd_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign div_start = (op == OP_DIV_K) || (op == OP_DIV_J);
   assign div_num   = (op == OP_DIV_J) ? rest_ff : cnt_ff;
   assign div_den   = (op == OP_DIV_J) ? j_ff : k_ff;

   // A non-periodic axis has one cut plane fewer than it has processors.
   assign fk = cfg.wz ? k_ff : k_ff - 1'b1;
   assign fj = cfg.wy ? j_ff : j_ff - 1'b1;
   assign fi = cfg.wx ? i_ff : i_ff - 1'b1;

   assign out_full = valid_ff && !rsp_tready;
   assign mul_p    = ACC_W'(mul_a) * ACC_W'(mul_b);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op)
         OP_MUL_XY: begin
            mul_a = PROD_W'(cfg.gx);
            mul_b = cfg.gy;
         end
         OP_MUL_XZ: begin
            mul_a = PROD_W'(cfg.gx);
            mul_b = cfg.gz;
         end
         OP_MUL_YZ: begin
            mul_a = PROD_W'(cfg.gy);
            mul_b = cfg.gz;
         end
         OP_BOUND: begin
            mul_a = xy_ff;
            mul_b = cfg.gz;
         end
         OP_MUL_ZK: begin
            mul_a = xy_ff;
            mul_b = fk;
         end
         OP_MUL_YJ: begin
            mul_a = xz_ff;
            mul_b = fj;
         end
         OP_MUL_XI: begin
            mul_a = yz_ff;
            mul_b = fi;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;  k_in = k_ff;  j_in = j_ff;  rest_in = rest_ff;  i_in = i_ff;
      xy_in = xy_ff;  xz_in = xz_ff;  yz_in = yz_ff;
      mul_in = mul_ff;  acc_in = acc_ff;  best_in = best_ff;
      bx_in = bx_ff;  by_in = by_ff;  bz_in = bz_ff;  hit_in = hit_ff;
      ox_in = ox_ff;  oy_in = oy_ff;  oz_in = oz_ff;  oa_in = oa_ff;  of_in = of_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      case (op)
         OP_LOAD: begin
            if (req_tvalid) begin
               cnt_in = (req_count > PROCS_MAX) ? PROCS_MAX : req_count;
               k_in   = CNT_W'(1);
               bx_in  = '0;
               by_in  = '0;
               bz_in  = '0;
               hit_in = 1'b0;
            end
         end
         OP_MUL_XY: begin
            xy_in = mul_p[PROD_W-1:0];
         end
         OP_MUL_XZ: begin
            xz_in = mul_p[PROD_W-1:0];
         end
         OP_MUL_YZ: begin
            yz_in = mul_p[PROD_W-1:0];
         end
         OP_BOUND: begin
            best_in = mul_p[AREA_W-1:0];
         end
         OP_SET_REST: begin
            rest_in = div_quo;
            j_in    = CNT_W'(1);
         end
         OP_SET_I: begin
            i_in = div_quo;
         end
         OP_MUL_ZK: begin
            mul_in = mul_p;
         end
         OP_MUL_YJ: begin
            acc_in = mul_ff;
            mul_in = mul_p;
         end
         OP_MUL_XI: begin
            acc_in = acc_ff + mul_ff;
            mul_in = mul_p;
         end
         OP_SUM: begin
            acc_in = acc_ff + mul_ff;
         end
         OP_KEEP: begin
            // Strictly below, so the first of equal areas is kept.
            if (acc_ff < ACC_W'(best_ff)) begin
               best_in = acc_ff[AREA_W-1:0];
               bx_in   = i_ff;
               by_in   = j_ff;
               bz_in   = k_ff;
               hit_in  = 1'b1;
            end
         end
         OP_INC_J: begin
            j_in = j_ff + 1'b1;
         end
         OP_INC_K: begin
            k_in = k_ff + 1'b1;
         end
         OP_OUT: begin
            if (!out_full) begin
               ox_in    = bx_ff;
               oy_in    = by_ff;
               oz_in    = bz_ff;
               oa_in    = best_ff;
               of_in    = hit_ff;
               valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cnt_ff <= cnt_in;  k_ff <= k_in;  j_ff <= j_in;  rest_ff <= rest_in;  i_ff <= i_in;
      xy_ff <= xy_in;  xz_ff <= xz_in;  yz_ff <= yz_in;
      mul_ff <= mul_in;  acc_ff <= acc_in;  best_ff <= best_in;
      bx_ff <= bx_in;  by_ff <= by_in;  bz_ff <= bz_in;  hit_ff <= hit_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;  oz_ff <= oz_in;  oa_ff <= oa_in;  of_ff <= of_in;
   end

   assign rsp_tvalid    = valid_ff;
   assign rsp_split_x   = ox_ff;
   assign rsp_split_y   = oy_ff;
   assign rsp_split_z   = oz_ff;
   assign rsp_best_area = oa_ff;
   assign rsp_found     = of_ff;

   assign status.div_busy  = div_busy;
   assign status.rem_nz    = div_rem != '0;
   assign status.k_gt_cnt  = k_ff > cnt_ff;
   assign status.j_gt_rest = j_ff > rest_ff;
   assign status.out_full  = out_full;

endmodule

### hw/rtl/pgd_sequencer.sv
// Microcode sequencer: step counter, program read from the package table and
// conditional jumps on datapath status. Depends on pgd_pkg.
`timescale 1ns / 1ps

module pgd_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  pgd_pkg::status_type status,
   output pgd_pkg::op_type     op
);
   import pgd_pkg::*;

   step_type  step_ff, step_in;
   ucode_type word;
   logic      take;

   always_comb begin
      word = pgd_ucode(step_ff);
      case (word.cond)
         C_NEXT:      take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_REQ:    take = !req_tvalid;
         C_DIV_BUSY:  take = status.div_busy;
         C_REM_NZ:    take = status.rem_nz;
         C_K_GT_CNT:  take = status.k_gt_cnt;
         C_J_GT_REST: take = status.j_gt_rest;
         C_OUT_FULL:  take = status.out_full;
         default:     take = 1'b1;
      endcase
      step_in = take ? word.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign op = word.op;

endmodule

### hw/rtl/processor_grid_decomposition_search.sv
// Processor grid decomposition search, top level: configuration registers and streams.
// Every k and j trial waits on the divider.
// One transaction at a time: the next request is taken only when the program has come
// back to its first step after the result is loaded.
// Synchronous reset sets the grid to 1 x 1 x 1 with no periodic axis; no clearing pass.
`timescale 1ns / 1ps

module processor_grid_decomposition_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [12:0] proc_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [12:0] split_x, [25:13] split_y, [38:26] split_z,
                                    // [75:39] best_area
   output logic        rsp_tuser,   // [0] found
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import pgd_pkg::*;

   cnt_type gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic    wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;

   cfg_type    cfg;
   op_type     op;
   status_type status;
   cnt_type    split_x, split_y, split_z;
   area_type   best_area;

   always_comb begin
      gx_in = gx_ff;  gy_in = gy_ff;  gz_in = gz_ff;
      wx_in = wx_ff;  wy_in = wy_ff;  wz_in = wz_ff;
      if (csr_we) begin
         case (csr_index)
            REG_GRID_X: gx_in = csr_wdata;
            REG_GRID_Y: gy_in = csr_wdata;
            REG_GRID_Z: gz_in = csr_wdata;
            REG_WRAP_X: wx_in = csr_wdata[0];
            REG_WRAP_Y: wy_in = csr_wdata[0];
            REG_WRAP_Z: wz_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff <= CNT_W'(1);
         gy_ff <= CNT_W'(1);
         gz_ff <= CNT_W'(1);
         wx_ff <= 1'b0;
         wy_ff <= 1'b0;
         wz_ff <= 1'b0;
      end else begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         gz_ff <= gz_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         wz_ff <= wz_in;
      end
   end

   assign cfg.gx = (gx_ff > GRID_MAX) ? GRID_MAX : gx_ff;
   assign cfg.gy = (gy_ff > GRID_MAX) ? GRID_MAX : gy_ff;
   assign cfg.gz = (gz_ff > GRID_MAX) ? GRID_MAX : gz_ff;
   assign cfg.wx = wx_ff;
   assign cfg.wy = wy_ff;
   assign cfg.wz = wz_ff;

   pgd_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .op         (op)
   );

   pgd_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .cfg           (cfg),
      .req_tvalid    (req_tvalid),
      .req_count     (req_tdata[CNT_W-1:0]),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_split_x   (split_x),
      .rsp_split_y   (split_y),
      .rsp_split_z   (split_z),
      .rsp_best_area (best_area),
      .rsp_found     (rsp_tuser),
      .status        (status)
   );

   // The program waits at its first step until a request arrives.
   assign req_tready = (op == OP_LOAD);
   assign rsp_tdata  = {4'b0000, best_area, split_z, split_y, split_x};

endmodule
